### sv/gfcd_pkg.sv
// Package for the gated frequency counter display: widths, register codes,
// segment patterns and reciprocal constants for the decimal digit split.
// No dependencies.
`default_nettype none
package gfcd_pkg;

	localparam int NUM_DIGITS = 8;
	localparam int POS_W      = 3;
	localparam int VAL_W      = 16;
	localparam int SHIFT_W    = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_GATE_TICKS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RESULT_SHIFT = 2'd1;

	localparam logic [VAL_W-1:0]   GATE_TICKS_RST   = 16'd200;
	localparam logic [SHIFT_W-1:0] RESULT_SHIFT_RST = 3'd1;

	localparam logic [7:0] SEG_F     = 8'h8e;
	localparam logic [7:0] SEG_BLANK = 8'hff;

	localparam logic [7:0] SEG_DIGITS [10] = '{
		8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90
	};

	// display positions
	localparam logic [POS_W-1:0] POS_LETTER = 3'd0;
	localparam logic [POS_W-1:0] POS_BLANK1 = 3'd1;
	localparam logic [POS_W-1:0] POS_BLANK2 = 3'd2;

	// v / w == (v * ceil(2^30 / w)) >> 30, exact for every 16-bit v
	localparam int RECIP_W = 31;
	localparam int RECIP_S = 30;
	// q / 10 == (q * ceil(2^20 / 10)) >> 20, exact for every 16-bit q
	localparam int DIV10_W = 17;
	localparam int DIV10_S = 20;
	localparam logic [DIV10_W-1:0] DIV10_M = 17'd104858;
	localparam int QUO10_W = 13;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [POS_W-1:0] pos;
	} item_s1_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] quo;
	} item_s2_t;

	typedef struct packed {
		logic [VAL_W-1:0]   value;
		logic [POS_W-1:0]   pos;
		logic [VAL_W-1:0]   quo;
		logic [QUO10_W-1:0] quo10;
	} item_s3_t;

	// reciprocal of the decimal weight shown at a position
	function automatic logic [RECIP_W-1:0] recip_for(input logic [POS_W-1:0] pos);
		logic [RECIP_W-1:0] r;
		case (pos)
			3'd3:    r = 31'd107375;
			3'd4:    r = 31'd1073742;
			3'd5:    r = 31'd10737419;
			3'd6:    r = 31'd107374183;
			3'd7:    r = 31'd1073741824;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] seg_for_digit(input logic [3:0] digit);
		logic [7:0] s;
		if (digit < 4'd10) begin
			s = SEG_DIGITS[digit];
		end else begin
			s = SEG_BLANK;
		end
		return s;
	endfunction

endpackage
`default_nettype wire

### sv/gated_frequency_counter_display.sv
// Top level of the gated frequency counter display: handshake wiring of the
// gate logic and the display decode pipeline. Depends on gfcd_pkg,
// gfcd_gate and gfcd_decode.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  in      | input     | in_valid / in_stall  | edge_seen, tick_seen, digit_position
//  out     | output    | out_valid / out_stall| measured_value, digit_enable, segment_code
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One transaction per cycle while out_stall is low; a result passes stages 1 to 3,
// with the two multiplies of the digit split between them, then the output register.
// Counters and the latched value update at the accepting edge, so the next
// transaction sees them at once. Reset clears counters, latch and all valids.
// A held output fills the three inner stages before in_stall rises.
`default_nettype none
module gated_frequency_counter_display (
	input  wire                            clk,
	input  wire                            arst_n,
	// input transaction channel
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire                            edge_seen,
	input  wire                            tick_seen,
	input  wire [gfcd_pkg::POS_W-1:0]      digit_position,
	// result transaction channel
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [gfcd_pkg::VAL_W-1:0]     measured_value,
	output logic [gfcd_pkg::NUM_DIGITS-1:0] digit_enable,
	output logic [7:0]                     segment_code,
	// configuration write channel
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire [gfcd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [gfcd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import gfcd_pkg::*;

	logic     accept;
	logic     adv_s1;
	logic     valid_s1;
	item_s1_t item_s1;

	// registers take a write in any cycle
	assign cfg_ready = 1'b1;

	// stall the input only when stage 1 holds a transaction that cannot move
	assign in_stall = !adv_s1;
	assign accept   = in_valid && adv_s1;

	gfcd_gate u_gate (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.accept         (accept),
		.edge_seen      (edge_seen),
		.tick_seen      (tick_seen),
		.digit_position (digit_position),
		.adv_s1         (adv_s1),
		.valid_s1       (valid_s1),
		.item_s1        (item_s1)
	);

	gfcd_decode u_decode (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s1       (valid_s1),
		.item_s1        (item_s1),
		.adv_s1         (adv_s1),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.measured_value (measured_value),
		.digit_enable   (digit_enable),
		.segment_code   (segment_code)
	);

endmodule
`default_nettype wire

### sv/gfcd_gate.sv
// Gate logic: configuration registers, edge and tick counters, latched value
// and the first pipeline register. Depends on gfcd_pkg.
`default_nettype none
module gfcd_gate (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire [gfcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [gfcd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire                           accept,
	input  wire                           edge_seen,
	input  wire                           tick_seen,
	input  wire [gfcd_pkg::POS_W-1:0]     digit_position,
	input  wire                           adv_s1,
	output logic                          valid_s1,
	output gfcd_pkg::item_s1_t            item_s1
);
	import gfcd_pkg::*;

	logic [VAL_W-1:0]   gate_ticks_q;
	logic [SHIFT_W-1:0] result_shift_q;
	logic [VAL_W-1:0]   edge_q, tick_q, latched_q;
	logic [VAL_W-1:0]   edge_next, tick_inc, edge_d, tick_d, latched_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_ticks_q   <= GATE_TICKS_RST;
			result_shift_q <= RESULT_SHIFT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GATE_TICKS:   gate_ticks_q   <= cfg_data;
				CFG_RESULT_SHIFT: result_shift_q <= cfg_data[SHIFT_W-1:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		edge_next = edge_seen ? edge_q + 16'd1 : edge_q;
		tick_inc  = tick_q + 16'd1;
		edge_d    = edge_next;
		tick_d    = tick_q;
		latched_d = latched_q;
		if (tick_seen) begin
			if (tick_inc == gate_ticks_q) begin
				// close the gate: the edge of this item counts too
				latched_d = edge_next >> result_shift_q;
				edge_d    = '0;
				tick_d    = '0;
			end else begin
				tick_d = tick_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_q    <= '0;
			tick_q    <= '0;
			latched_q <= '0;
		end else if (accept) begin
			edge_q    <= edge_d;
			tick_q    <= tick_d;
			latched_q <= latched_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.value <= latched_d;
			item_s1.pos   <= digit_position;
		end
	end

endmodule
`default_nettype wire

### sv/gfcd_decode.sv
// Display decode pipeline: reciprocal division by the position weight,
// mod-10 split, segment lookup and the output register. Depends on gfcd_pkg.
`default_nettype none
module gfcd_decode (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                valid_s1,
	input  wire gfcd_pkg::item_s1_t            item_s1,
	output logic                               adv_s1,
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic [gfcd_pkg::VAL_W-1:0]         measured_value,
	output logic [gfcd_pkg::NUM_DIGITS-1:0]    digit_enable,
	output logic [7:0]                         segment_code
);
	import gfcd_pkg::*;

	logic     valid_s2, valid_s3;
	item_s2_t item_s2;
	item_s3_t item_s3;
	logic     adv_s2, adv_s3, adv_out;

	logic [VAL_W+RECIP_W-1:0]   prod_w;
	logic [VAL_W+DIV10_W-1:0]   prod_10;
	logic [VAL_W-1:0]           digit_full;
	logic [3:0]                 digit;
	logic [7:0]                 seg_d;

	// advance a stage when it is empty or the next one advances
	assign adv_out = !out_valid || !out_stall;
	assign adv_s3  = !valid_s3 || adv_out;
	assign adv_s2  = !valid_s2 || adv_s3;
	assign adv_s1  = !valid_s1 || adv_s2;

	assign prod_w  = (VAL_W+RECIP_W)'(item_s1.value) *
	                 (VAL_W+RECIP_W)'(recip_for(item_s1.pos));
	assign prod_10 = (VAL_W+DIV10_W)'(item_s2.quo) * (VAL_W+DIV10_W)'(DIV10_M);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
			if (adv_out) out_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			item_s2.value <= item_s1.value;
			item_s2.pos   <= item_s1.pos;
			item_s2.quo   <= prod_w[RECIP_S +: VAL_W];
		end
		if (adv_s3 && valid_s2) begin
			item_s3.value <= item_s2.value;
			item_s3.pos   <= item_s2.pos;
			item_s3.quo   <= item_s2.quo;
			item_s3.quo10 <= prod_10[DIV10_S +: QUO10_W];
		end
		if (adv_out && valid_s3) begin
			measured_value <= item_s3.value;
			digit_enable   <= NUM_DIGITS'(1) << item_s3.pos;
			segment_code   <= seg_d;
		end
	end

	always_comb begin
		digit_full = item_s3.quo - VAL_W'(item_s3.quo10) * VAL_W'(10);
		digit      = digit_full[3:0];
		if (item_s3.pos == POS_LETTER) begin
			seg_d = SEG_F;
		end else if (item_s3.pos inside {POS_BLANK1, POS_BLANK2}) begin
			seg_d = SEG_BLANK;
		end else if (item_s3.quo == '0) begin
			// value below the position weight: leading zero
			seg_d = SEG_BLANK;
		end else begin
			seg_d = seg_for_digit(digit);
		end
	end

	a_enable_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot(digit_enable))
		else $error("digit enable not one-hot");

	a_letter_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && digit_enable[0] |-> segment_code == SEG_F)
		else $error("position 0 does not show F");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> digit_full < VAL_W'(10))
		else $error("mod-10 split out of range");

	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> item_s2.quo <= item_s2.value)
		else $error("quotient exceeds dividend");

	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !adv_out |=> valid_s3 && $stable(item_s3))
		else $error("stage 3 lost a held transaction");

endmodule
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for gated_frequency_counter_display: predicts every display
// transaction in-line from the sample stream and the register writes. Depends on
// gfcd_pkg and the block's RTL only.
module testbench;
	import gfcd_pkg::*;

	// Input transaction to display transaction, in cycles.
	localparam int DISPLAY_LATENCY = 3;
	// Indexes the port can carry but that address no register.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
	localparam int IDLE_PCT = 38;

	typedef struct {
		logic [VAL_W-1:0]      value;
		logic [NUM_DIGITS-1:0] enable;
		logic [7:0]            segments;
	} display_word_t;

	logic                  clk            = 1'b0;
	logic                  arst_n         = 1'b0;
	logic                  in_valid       = 1'b0;
	logic                  in_stall;
	logic                  edge_seen      = 1'b0;
	logic                  tick_seen      = 1'b0;
	logic [POS_W-1:0]      digit_position = '0;
	logic                  out_valid;
	logic                  out_stall      = 1'b0;
	logic [VAL_W-1:0]      measured_value;
	logic [NUM_DIGITS-1:0] digit_enable;
	logic [7:0]            segment_code;
	logic                  cfg_valid      = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index      = '0;
	logic [CFG_DATA_W-1:0] cfg_data       = '0;

	// Predictor state: counters, latch and the two registers as the block holds them.
	logic [VAL_W-1:0]   edge_count;
	logic [VAL_W-1:0]   tick_count;
	logic [VAL_W-1:0]   latched_hz;
	logic [VAL_W-1:0]   gate_len;
	logic [SHIFT_W-1:0] scale_shift;
	int unsigned        gates_closed;

	display_word_t expected_words[$];
	display_word_t head;
	int unsigned   mismatches = 0;
	// Clear to run both sides flat out.
	bit            idle_on    = 1'b1;

	gated_frequency_counter_display DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.edge_seen      (edge_seen),
		.tick_seen      (tick_seen),
		.digit_position (digit_position),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.measured_value (measured_value),
		.digit_enable   (digit_enable),
		.segment_code   (segment_code),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #5 clk = ~clk;

	// Stall the result channel at random while idling is on.
	always @(posedge clk) begin
		out_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
	end

	// Segment pattern a position should show for a latched value: F on the left,
	// two blanks, then five decimal digits with leading zeros blanked.
	function automatic logic [7:0] expected_segment(input logic [POS_W-1:0] p,
			input logic [VAL_W-1:0] v);
		int unsigned weight;
		weight = 1;
		if (p == POS_LETTER)
			return SEG_F;
		if (p == POS_BLANK1 || p == POS_BLANK2)
			return SEG_BLANK;
		for (int i = p; i < NUM_DIGITS - 1; i++)
			weight *= 10;
		if (v < weight)
			return SEG_BLANK;
		return SEG_DIGITS[(v / weight) % 10];
	endfunction

	// Advance the counters for one accepted sample and queue the display word.
	// The edge counts before the tick, so an edge on the closing tick is measured.
	task automatic predict_word(input logic e, input logic t, input logic [POS_W-1:0] p);
		display_word_t w;
		if (e)
			edge_count += 16'd1;
		if (t) begin
			tick_count += 16'd1;
			// equality only: a gate below the running count waits for the wrap
			if (tick_count == gate_len) begin
				latched_hz   = edge_count >> scale_shift;
				edge_count   = '0;
				tick_count   = '0;
				gates_closed++;
			end
		end
		w.value    = latched_hz;
		w.enable   = NUM_DIGITS'(1) << p;
		w.segments = expected_segment(p, latched_hz);
		expected_words.push_back(w);
	endtask

	// Send one sample transaction. Hold valid high across back-to-back samples
	// and drop it only while idling, so valid never toggles within one step.
	task automatic send_sample(input logic e, input logic t, input logic [POS_W-1:0] p);
		while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		edge_seen      <= e;
		tick_seen      <= t;
		digit_position <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_word(e, t, p);
	endtask

	task automatic send_random(input int edge_pct, input int tick_pct);
		send_sample($urandom_range(0, 99) < edge_pct, $urandom_range(0, 99) < tick_pct,
			POS_W'($urandom_range(0, NUM_DIGITS - 1)));
	endtask

	// Drop valid, wait for every expected display transaction, then let the
	// pipeline empty before anything touches the registers.
	task automatic settle_display();
		in_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DISPLAY_LATENCY) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_GATE_TICKS:   gate_len    = data;
			CFG_RESULT_SHIFT: scale_shift = data[SHIFT_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Settle, then write both registers; the shift write carries random upper bits.
	task automatic set_gate_and_shift(input logic [VAL_W-1:0] gate,
			input logic [SHIFT_W-1:0] shift);
		settle_display();
		write_register(CFG_GATE_TICKS, gate);
		write_register(CFG_RESULT_SHIFT,
			CFG_DATA_W'($urandom_range(0, 8191) << SHIFT_W) | CFG_DATA_W'(shift));
	endtask

	// Run on the reset settings until one full gate of 200 ticks has closed.
	task automatic test_reset_defaults();
		int unsigned closed_at_start;
		closed_at_start = gates_closed;
		while (gates_closed == closed_at_start)
			send_random(60, 70);
		repeat (16) send_random(50, 0);
	endtask

	// Short hand-picked sequence: blank zero display, one-tick gates, the edge on
	// the closing tick, a tick with no edge, and every display position.
	task automatic test_directed();
		set_gate_and_shift(16'd1, 3'd0);
		for (int p = 0; p < NUM_DIGITS; p++)
			send_sample(1'b0, 1'b0, POS_W'(p));
		send_sample(1'b1, 1'b1, 3'd3);
		send_sample(1'b0, 1'b0, 3'd7);
		send_sample(1'b1, 1'b0, 3'd7);
		send_sample(1'b0, 1'b1, 3'd7);
		send_sample(1'b0, 1'b1, 3'd7);
		for (int p = 0; p < NUM_DIGITS; p++)
			send_sample(1'b1, 1'b0, POS_W'(p));
		send_sample(1'b1, 1'b1, 3'd6);
	endtask

	// Random samples over a spread of register settings, extremes included.
	task automatic test_random_settings();
		// one-tick gate with the largest shift
		set_gate_and_shift(16'd1, 3'd7);
		repeat (120) send_random(50, 50);
		// longest gate: the latch holds
		set_gate_and_shift(16'hffff, 3'd0);
		repeat (60) send_random(50, 50);
		// short gates, small shifts
		for (int k = 0; k < 5; k++) begin
			set_gate_and_shift(VAL_W'($urandom_range(2, 12)), SHIFT_W'($urandom_range(0, 3)));
			repeat (50) send_random(80, 40);
		end
		// longer gates with dense edges so that large shifts leave something
		for (int k = 0; k < 3; k++) begin
			set_gate_and_shift(VAL_W'($urandom_range(20, 40)), SHIFT_W'($urandom_range(2, 7)));
			repeat (110) send_random(95, 15);
		end
		// writes to unmapped indexes change nothing
		settle_display();
		write_register(CFG_SPARE_2, CFG_DATA_W'($urandom));
		write_register(CFG_SPARE_3, CFG_DATA_W'($urandom));
		repeat (40) send_random(70, 50);
		set_gate_and_shift(VAL_W'($urandom_range(1, 6)), 3'd0);
		repeat (100) send_random(70, 50);
	endtask

	// Both channels flat out: no gaps and no stalls.
	task automatic test_no_idle();
		idle_on = 1'b0;
		repeat (150) send_random(70, 50);
		idle_on = 1'b1;
	endtask

	// Stop sending mid-stream until every display transaction is back, then resume.
	task automatic test_drain_pause();
		repeat (30) send_random(60, 40);
		settle_display();
		repeat (30) send_random(60, 40);
	endtask

	// Move the gate below the running tick count: the compare is for equality
	// only, so the gate stays open and the latch holds while edges pile up.
	task automatic test_gate_below_count();
		set_gate_and_shift(16'hffff, 3'd0);
		repeat (10) send_sample(1'b1, 1'b1, POS_W'($urandom_range(0, NUM_DIGITS - 1)));
		settle_display();
		write_register(CFG_GATE_TICKS, tick_count - 16'd3);
		repeat (40) send_random(90, 60);
	endtask

	// Check each accepted display transaction against the oldest prediction.
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$error("unexpected display transaction: %0d %h %h",
					measured_value, digit_enable, segment_code);
				mismatches++;
			end else begin
				head = expected_words.pop_front();
				if (measured_value !== head.value) begin
					$error("measured_value: expected %0d, actual %0d", head.value, measured_value);
					mismatches++;
				end
				if (digit_enable !== head.enable) begin
					$error("digit_enable: expected %h, actual %h", head.enable, digit_enable);
					mismatches++;
				end
				if (segment_code !== head.segments) begin
					$error("segment_code: expected %h, actual %h", head.segments, segment_code);
					mismatches++;
				end
			end
		end
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		// mirror the reset state in the predictor
		edge_count   = '0;
		tick_count   = '0;
		latched_hz   = '0;
		gate_len     = 16'd200;
		scale_shift  = 3'd1;
		gates_closed = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_directed();
		test_random_settings();
		test_no_idle();
		test_drain_pause();
		test_gate_below_count();

		// drain, then give stray transactions time to show up
		settle_display();
		repeat (DISPLAY_LATENCY * 4) @(posedge clk);
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
